### src/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, word layouts, command classes and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELL_COUNT  = ROWS * COLUMNS;
	localparam int ADDR_W      = $clog2(CELL_COUNT);
	localparam int SUM_W       = ADDR_W + 1;

	localparam int ROW_W       = 5;
	localparam int COL_W       = 7;
	localparam int IDX_W       = 11;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = ATTR_W + CHAR_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_CHAR,
		K_NEWLINE,
		K_RETURN,
		K_CLEAR,
		K_READ,
		K_NOP
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_SCROLL,
		ST_CLEAR,
		ST_READ,
		ST_DATA
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} in_word_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_word;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
	} out_word_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} cmd_t;

endpackage

### src/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front: input side of the text console writer
// Classifies each accepted word into a command and queues it for the back end.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_word,
	output logic     q_valid,
	input  logic     q_pop,
	output cmd_t     q_cmd
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cmd_in;
	logic              push;
	logic              pop;

	// Decode the operation and the special characters up front.
	always_comb begin
		cmd_in.char_code  = in_word.char_code;
		cmd_in.cell_index = in_word.cell_index;
		unique case (op_t'(in_word.operation))
			OP_PUT: begin
				if (in_word.char_code == CH_NEWLINE) begin
					cmd_in.kind = K_NEWLINE;
				end else if (in_word.char_code == CH_RETURN) begin
					cmd_in.kind = K_RETURN;
				end else begin
					cmd_in.kind = K_CHAR;
				end
			end
			OP_CLEAR: cmd_in.kind = K_CLEAR;
			OP_READ:  cmd_in.kind = K_READ;
			default:  cmd_in.kind = K_NOP;
		endcase
	end

	assign in_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_cmd    = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back: execution side of the text console writer
// Runs queued commands against the screen RAM, keeps cursor and scroll ring.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              attr_we,
	input  logic [ATTR_W-1:0] attr_wdata,
	input  logic              q_valid,
	output logic              q_pop,
	input  cmd_t              q_cmd,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [CELL_W-1:0] ram_wdata,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [CELL_W-1:0] ram_rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_word
);

	state_t            state_q, state_d;
	logic [ATTR_W-1:0] attr_q;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [ADDR_W-1:0] sweep_q, sweep_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	cmd_t              cmd_q, cmd_d;
	logic              out_valid_q, out_valid_d;
	out_word_t         out_word_q;
	logic              emit;
	logic [CELL_W-1:0] emit_word;
	logic              res_free;
	logic [SUM_W-1:0]  phys_sum;
	logic [ADDR_W-1:0] phys_addr;
	logic [SUM_W-1:0]  base_sum;
	logic [ADDR_W-1:0] base_next;
	logic [ADDR_W-1:0] cursor_lin;
	logic              idx_in_range;
	logic [CELL_W-1:0] blank;

	assign res_free = !out_valid_q || out_ready;
	assign blank    = {attr_q, CH_SPACE};

	// Logical cell address rotated by the ring base.
	assign phys_sum  = SUM_W'(addr_q) + SUM_W'(base_q);
	assign phys_addr = (phys_sum >= SUM_W'(CELL_COUNT)) ?
		ADDR_W'(phys_sum - SUM_W'(CELL_COUNT)) : ADDR_W'(phys_sum);

	// Advance the ring base one row; it lands exactly on the store size when it wraps.
	assign base_sum  = SUM_W'(base_q) + SUM_W'(COLUMNS);
	assign base_next = (base_sum >= SUM_W'(CELL_COUNT)) ? '0 : ADDR_W'(base_sum);

	assign cursor_lin   = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign idx_in_range = (32'(cmd_q.cell_index) < CELL_COUNT);

	assign ram_raddr = phys_addr;

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		base_d    = base_q;
		sweep_d   = sweep_q;
		addr_d    = addr_q;
		cmd_d     = cmd_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_word = '0;
		ram_we    = 1'b0;
		ram_waddr = phys_addr;
		ram_wdata = blank;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					cmd_d   = q_cmd;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_q.kind)
					K_NOP: begin
						if (res_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
					K_RETURN: begin
						if (res_free) begin
							col_d   = '0;
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
					K_NEWLINE: begin
						if (row_q == LAST_ROW) begin
							col_d   = '0;
							sweep_d = '0;
							state_d = ST_SCROLL;
						end else if (res_free) begin
							col_d   = '0;
							row_d   = row_q + 1'b1;
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
					K_CHAR: begin
						addr_d  = cursor_lin;
						state_d = ST_WRITE;
					end
					K_CLEAR: begin
						sweep_d = '0;
						state_d = ST_CLEAR;
					end
					K_READ: begin
						if (idx_in_range) begin
							addr_d  = ADDR_W'(cmd_q.cell_index);
							state_d = ST_READ;
						end else if (res_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_WRITE: begin
				// Rewriting the same cell while the result register is blocked is harmless.
				ram_we    = 1'b1;
				ram_wdata = {attr_q, cmd_q.char_code};
				if (col_q == LAST_COL) begin
					if (row_q == LAST_ROW) begin
						col_d   = '0;
						sweep_d = '0;
						state_d = ST_SCROLL;
					end else if (res_free) begin
						col_d   = '0;
						row_d   = row_q + 1'b1;
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (res_free) begin
					col_d   = col_q + 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCROLL: begin
				// Blank the oldest physical row, which becomes the new bottom row.
				ram_we    = 1'b1;
				ram_waddr = base_q + sweep_q;
				if (sweep_q == ADDR_W'(COLUMNS - 1)) begin
					if (res_free) begin
						base_d  = base_next;
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				if (sweep_q == ADDR_W'(CELL_COUNT - 1)) begin
					if (res_free) begin
						base_d  = '0;
						row_d   = '0;
						col_d   = '0;
						emit    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			ST_READ: begin
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (res_free) begin
					emit_word = ram_rdata;
					emit      = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			attr_q      <= ATTR_RESET;
			row_q       <= '0;
			col_q       <= '0;
			base_q      <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			col_q       <= col_d;
			base_q      <= base_d;
			sweep_q     <= sweep_d;
			out_valid_q <= out_valid_d;
			if (attr_we) begin
				attr_q <= attr_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		addr_q <= addr_d;
		if (emit) begin
			out_word_q <= '{cell_word: emit_word, cursor_row: row_d, cursor_col: col_d};
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

### src/text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit: character-cell text console
// Keeps an 80 x 25 screen of attribute/character cells and a cursor; puts
// characters, clears the screen and reads cells back.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------
//   in       | in        | in_valid / in_ready  | in_word  (operation, char, index)
//   out      | out       | out_valid / out_ready| out_word (cell, cursor row/col)
//   attr     | in        | attr_we (no stall)   | attr_wdata (attribute byte)
//
// Newline, carriage return, unused codes and reads outside the store end in the
// execute state; a printable character adds the write state and a read inside the
// store the read and data states; a scroll or clear blanks cells on one write port.
// Reset: cursor and scroll ring go home, attribute returns to 0x0F; the screen RAM
// holds garbage until the first clear. Stalls: the two-deep front queue takes words
// while the back end works; the back end holds on an empty queue or a full result.
//
module text_console_writer_unit import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_word,
	input  logic              attr_we,
	input  logic [ATTR_W-1:0] attr_wdata
);

	// Queue between front and back end.
	logic              q_valid;
	logic              q_pop;
	cmd_t              q_cmd;

	// Screen RAM ports.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Classify incoming words and hold them in a two-deep queue.
	tcw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd)
	);

	// Execute commands: cursor, scroll ring, sweeps and the result register.
	tcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.attr_we    (attr_we),
		.attr_wdata (attr_wdata),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_cmd      (q_cmd),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

	// Screen store, addressed physically; rows rotate through a ring base.
	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for text_console_writer_unit
// Drives put, clear, read and unused-code words through the valid/ready input
// channel, predicts every result word with a behavioral copy of the screen and
// cursor, and checks each result field by field in arrival order. A short
// table of directed words comes first, then randomized well-formed text,
// newline bursts, read bursts, clears and noise under several attributes and
// idling mixes.
// ----------------------------------------------------------------------------
module tb;
	import tcw_pkg::*;

	// One directed stimulus row; want is used only when typed is set.
	typedef struct {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		bit                typed;
		out_word_t         want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 24;
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_WORDS = 105;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_word_t          in_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_word_t         out_word;
	logic              attr_we = 1'b0;
	logic [ATTR_W-1:0] attr_wdata = '0;

	// Idle percentages for the sender and the receiver.
	int send_idle = 15;
	int recv_idle = 80;
	int failures = 0;
	int seg_items = 0;

	// Behavioral copy of the console.
	logic [CELL_W-1:0] model_screen [CELL_COUNT];
	int                model_row = 0;
	int                model_col = 0;
	logic [ATTR_W-1:0] model_attr = ATTR_RESET;

	out_word_t pending_words [$];
	stim_row_t directed_rows [DIRECTED_ROWS];

	text_console_writer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.attr_we    (attr_we),
		.attr_wdata (attr_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Move to column 0 of the next row; scroll up and blank the bottom row
	// when the cursor falls off the last row.
	function automatic void advance_line();
		model_col = 0;
		model_row++;
		if (model_row >= ROWS) begin
			for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
				model_screen[i] = model_screen[i + COLUMNS];
			for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
				model_screen[i] = {model_attr, CH_SPACE};
			model_row = ROWS - 1;
		end
	endfunction

	// Apply one input word to the console copy and return the result word.
	function automatic out_word_t next_console_word(in_word_t w);
		out_word_t r;
		logic [CELL_W-1:0] cell_val;
		cell_val = '0;
		case (op_t'(w.operation))
			OP_PUT: begin
				if (w.char_code == CH_NEWLINE) begin
					advance_line();
				end else if (w.char_code == CH_RETURN) begin
					model_col = 0;
				end else begin
					model_screen[model_row * COLUMNS + model_col] = {model_attr, w.char_code};
					model_col++;
					if (model_col >= COLUMNS)
						advance_line();
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					model_screen[i] = {model_attr, CH_SPACE};
				model_row = 0;
				model_col = 0;
			end
			OP_READ: begin
				if (w.cell_index < CELL_COUNT)
					cell_val = model_screen[w.cell_index];
			end
			default: begin
			end
		endcase
		r.cell_word  = cell_val;
		r.cursor_row = ROW_W'(model_row);
		r.cursor_col = COL_W'(model_col);
		return r;
	endfunction

	function automatic stim_row_t dir_row(op_t op, logic [CHAR_W-1:0] ch,
			logic [IDX_W-1:0] idx, bit typed, logic [CELL_W-1:0] cw,
			logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		stim_row_t s;
		s.op = op;
		s.ch = ch;
		s.idx = idx;
		s.typed = typed;
		s.want.cell_word = cw;
		s.want.cursor_row = r;
		s.want.cursor_col = c;
		return s;
	endfunction

	// Present one word, hold it until accepted, then queue its expected result.
	task automatic send_word(in_word_t w, bit typed, out_word_t want);
		int gap;
		out_word_t pred;
		gap = 0;
		while ($urandom_range(99) < send_idle && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		pred = next_console_word(w);
		pending_words.push_back(typed ? want : pred);
	endtask

	// Random word checked against the predictor; unused codes do not count.
	task automatic send_op(op_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
		in_word_t w;
		w.operation = op;
		w.char_code = ch;
		w.cell_index = idx;
		if (op != OP_NOP)
			seg_items++;
		send_word(w, 1'b0, '0);
	endtask

	// Drain all results, let any trailing back-end work finish, then write
	// the attribute register.
	task automatic write_attribute(logic [ATTR_W-1:0] value);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (COLUMNS + 8) @(posedge clk);
		attr_wdata <= value;
		attr_we <= 1'b1;
		@(posedge clk);
		attr_we <= 1'b0;
		model_attr = value;
	endtask

	// Receiver: stall at random according to recv_idle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Check each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word: cell %h row %0d col %0d",
					out_word.cell_word, out_word.cursor_row, out_word.cursor_col);
				failures++;
			end else begin
				want = pending_words.pop_front();
				if (out_word.cell_word !== want.cell_word) begin
					$error("cell_word: expected %h, got %h", want.cell_word, out_word.cell_word);
					failures++;
				end
				if (out_word.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d",
						want.cursor_row, out_word.cursor_row);
					failures++;
				end
				if (out_word.cursor_col !== want.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d",
						want.cursor_col, out_word.cursor_col);
					failures++;
				end
			end
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#(5_000_000);
		$display("text_console_writer_unit regression: fail");
		$finish;
	end

	initial begin
		logic [ATTR_W-1:0] attr_plan [SEGMENTS];
		in_word_t w;
		int pick;
		int len;
		int drain_cycles;
		logic [CHAR_W-1:0] ch;

		for (int i = 0; i < CELL_COUNT; i++)
			model_screen[i] = '0;

		// Directed table. The attribute is still at its reset value, and no
		// cell inside the store is read before the first clear.
		directed_rows[0]  = dir_row(OP_NOP,   8'hFF, 11'h7FF, 1, 16'h0000, 0, 0);
		directed_rows[1]  = dir_row(OP_READ,  8'h00, 11'h7FF, 1, 16'h0000, 0, 0);
		directed_rows[2]  = dir_row(OP_READ,  8'hFF, 11'd2000, 1, 16'h0000, 0, 0);
		directed_rows[3]  = dir_row(OP_PUT,   8'h41, 11'h000, 1, 16'h0000, 0, 1);
		directed_rows[4]  = dir_row(OP_CLEAR, 8'h00, 11'h7FF, 1, 16'h0000, 0, 0);
		directed_rows[5]  = dir_row(OP_READ,  8'h00, 11'd0,   1, 16'h0F20, 0, 0);
		directed_rows[6]  = dir_row(OP_READ,  8'hFF, 11'd1999, 1, 16'h0F20, 0, 0);
		directed_rows[7]  = dir_row(OP_PUT,   8'h00, 11'h000, 1, 16'h0000, 0, 1);
		directed_rows[8]  = dir_row(OP_PUT,   8'hFF, 11'h7FF, 1, 16'h0000, 0, 2);
		directed_rows[9]  = dir_row(OP_READ,  8'h00, 11'd0,   1, 16'h0F00, 0, 2);
		directed_rows[10] = dir_row(OP_READ,  8'h00, 11'd1,   1, 16'h0FFF, 0, 2);
		directed_rows[11] = dir_row(OP_PUT,   CH_RETURN, 11'h000, 1, 16'h0000, 0, 0);
		directed_rows[12] = dir_row(OP_PUT,   8'h7F, 11'h555, 0, '0, 0, 0);
		directed_rows[13] = dir_row(OP_PUT,   CH_NEWLINE, 11'h2AA, 1, 16'h0000, 1, 0);
		directed_rows[14] = dir_row(OP_READ,  8'h00, 11'd0,   0, '0, 0, 0);
		directed_rows[15] = dir_row(OP_PUT,   8'h80, 11'h000, 0, '0, 0, 0);
		directed_rows[16] = dir_row(OP_NOP,   CH_NEWLINE, 11'h000, 0, '0, 0, 0);
		directed_rows[17] = dir_row(OP_READ,  8'h00, 11'd80,  0, '0, 0, 0);
		directed_rows[18] = dir_row(OP_READ,  8'h00, 11'd1999, 0, '0, 0, 0);
		directed_rows[19] = dir_row(OP_PUT,   CH_SPACE, 11'h000, 0, '0, 0, 0);
		directed_rows[20] = dir_row(OP_CLEAR, 8'hFF, 11'h000, 1, 16'h0000, 0, 0);
		directed_rows[21] = dir_row(OP_READ,  8'h00, 11'd80,  1, 16'h0F20, 0, 0);
		directed_rows[22] = dir_row(OP_PUT,   CH_NEWLINE, 11'h000, 0, '0, 0, 0);
		directed_rows[23] = dir_row(OP_PUT,   CH_RETURN, 11'h7FF, 0, '0, 0, 0);

		attr_plan[0] = 8'hFF;
		attr_plan[1] = 8'h00;
		attr_plan[2] = ATTR_W'($urandom_range(255));
		attr_plan[3] = 8'h80;
		attr_plan[4] = 8'h7F;
		attr_plan[5] = ATTR_W'($urandom_range(255));

		// Hold reset, then release it at a clock edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			w.operation = directed_rows[i].op;
			w.char_code = directed_rows[i].ch;
			w.cell_index = directed_rows[i].idx;
			send_word(w, directed_rows[i].typed, directed_rows[i].want);
		end
		in_valid <= 1'b0;

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			// The sender waits here until every result is in.
			write_attribute(attr_plan[seg]);
			if (seg == 2) begin
				send_idle = 80;
				recv_idle = 15;
			end else if (seg == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			seg_items = 0;
			while (seg_items < SEGMENT_WORDS) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					// A line of text: mostly short, sometimes long enough to wrap.
					len = ($urandom_range(9) == 0) ? $urandom_range(90, 70) : $urandom_range(20, 1);
					for (int k = 0; k < len; k++) begin
						ch = CHAR_W'($urandom_range(255));
						if (ch == CH_NEWLINE || ch == CH_RETURN)
							ch = ch ^ 8'h40;
						send_op(OP_PUT, ch, IDX_W'($urandom_range(2047)));
					end
					pick = $urandom_range(9);
					if (pick < 2)
						send_op(OP_PUT, CH_RETURN, IDX_W'($urandom_range(2047)));
					if (pick < 7)
						send_op(OP_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
				end else if (pick < 60) begin
					// Newline burst: drive the cursor down and scroll.
					len = $urandom_range(30, 1);
					for (int k = 0; k < len; k++)
						send_op(OP_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
				end else if (pick < 85) begin
					// Read burst, mostly inside the store.
					len = $urandom_range(8, 1);
					for (int k = 0; k < len; k++) begin
						if ($urandom_range(9) == 0)
							send_op(OP_READ, CHAR_W'($urandom_range(255)),
								IDX_W'($urandom_range(2047, CELL_COUNT)));
						else
							send_op(OP_READ, CHAR_W'($urandom_range(255)),
								IDX_W'($urandom_range(CELL_COUNT - 1)));
					end
				end else if (pick < 97) begin
					// Noise: any put, read or unused code with raw fields.
					case ($urandom_range(2))
						0: send_op(OP_PUT, CHAR_W'($urandom_range(255)),
							IDX_W'($urandom_range(2047)));
						1: send_op(OP_READ, CHAR_W'($urandom_range(255)),
							IDX_W'($urandom_range(2047)));
						default: send_op(OP_NOP, CHAR_W'($urandom_range(255)),
							IDX_W'($urandom_range(2047)));
					endcase
				end else begin
					send_op(OP_CLEAR, CHAR_W'($urandom_range(255)),
						IDX_W'($urandom_range(2047)));
				end
			end
			in_valid <= 1'b0;
		end

		// Drain, then watch a while longer for stray result words.
		drain_cycles = 0;
		while (pending_words.size() != 0 && drain_cycles < 200000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (2 * COLUMNS + 40) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d result words never arrived", pending_words.size());
			failures++;
		end

		if (failures == 0) begin
			$display("text_console_writer_unit regression: pass");
		end else begin
			$display("text_console_writer_unit regression: fail");
		end
		$finish;
	end

endmodule
